@@ rtl/core/rdf_pkg.sv @@
// Shared types, constants and lookup functions of the radix digit formatter.
package rdf_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_LOW   = 8'd32;
  localparam logic [7:0] CHAR_HIGH  = 8'd126;
  localparam logic [4:0] MIN_RADIX  = 5'd2;

  localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [4:0]  RST_SYMBOL_COUNT = 5'd10;
  localparam logic [63:0] RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [63:0] RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
    logic [3:0]  rem;
  } div_result_t;

  // Symbol number idx of the packed 16-entry symbol table.
  function automatic logic [7:0] sym_at(input logic [127:0] syms, input logic [3:0] idx);
    sym_at = syms[idx*8 +: 8];
  endfunction

  // floor(2^32 / radix); zero for radixes that are never used.
  function automatic logic [31:0] recip_of(input logic [4:0] radix);
    case (radix)
      5'd2:    recip_of = 32'h8000_0000;
      5'd3:    recip_of = 32'h5555_5555;
      5'd4:    recip_of = 32'h4000_0000;
      5'd5:    recip_of = 32'h3333_3333;
      5'd6:    recip_of = 32'h2AAA_AAAA;
      5'd7:    recip_of = 32'h2492_4924;
      5'd8:    recip_of = 32'h2000_0000;
      5'd9:    recip_of = 32'h1C71_C71C;
      5'd10:   recip_of = 32'h1999_9999;
      5'd11:   recip_of = 32'h1745_D174;
      5'd12:   recip_of = 32'h1555_5555;
      5'd13:   recip_of = 32'h13B1_3B13;
      5'd14:   recip_of = 32'h1249_2492;
      5'd15:   recip_of = 32'h1111_1111;
      5'd16:   recip_of = 32'h1000_0000;
      default: recip_of = 32'h0000_0000;
    endcase
  endfunction

endpackage

@@ rtl/core/radix_digit_formatter.sv @@
// Top level of the radix digit formatter: config registers, sequencer, output.
//
// Formats a signed 32-bit value as text in the configured radix (symbol_count,
// 2..MAX_SYMBOLS) using the configured symbol table. A transaction starts when
// start_i is high while busy_o is low. busy_o then stays high up to the edge
// that issues the last character, so the next transaction can be accepted in
// the cycle that carries the last character. Characters come out one per cycle,
// marked by symbol_valid_o for exactly one cycle each: a minus sign first for
// negative values, then the digits most significant first, is_last_o on the
// final one. The receiver cannot stall the stream. An invalid symbol set (or a
// count out of range) gives no characters at all. Each digit of a value passes
// through the shared reciprocal-multiply divider (multiply, back-multiply,
// correct, hand-off); then the symbol check is resolved, then the digit
// characters go out. The minus sign goes out in the cycle that resolves the
// check and costs nothing extra. busy_o spans this whole sequence, which is
// also the spacing of back-to-back values. The symbol check sweeps one symbol
// per cycle in parallel with the divider; when the sweep outlasts the digit
// conversion (short values, many symbols) the check sets the pace. A failed
// check ends the transaction at the same point without characters. Program
// the registers only while busy_o is low.
module radix_digit_formatter import rdf_pkg::*; #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] value_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  output logic               symbol_valid_o,
  output logic [7:0]         symbol_o,
  output logic               is_last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_WAIT,
    S_EMIT
  } fmt_state_e;

  // configuration registers
  logic [4:0]  count_q;
  logic [63:0] syms_low_q;
  logic [63:0] syms_high_q;
  logic [127:0] syms;

  fmt_state_e  state_q;
  logic        neg_q;
  logic [4:0]  wr_idx_q;
  logic [4:0]  rd_idx_q;
  logic        out_valid_q;
  logic [7:0]  symbol_q;
  logic        is_last_q;
  logic [3:0]  digits_q [32];

  logic        accept;
  logic        range_ok;
  logic        div_start;
  logic [31:0] mag_in;
  logic [31:0] div_dividend;
  div_result_t div_res;
  chk_status_t chk_res;

  assign syms = {syms_high_q, syms_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= RST_SYMBOL_COUNT;
      syms_low_q  <= RST_SYMBOLS_LOW;
      syms_high_q <= RST_SYMBOLS_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYMBOL_COUNT: count_q     <= cfg_wdata_i[4:0];
        CFG_SYMBOLS_LOW:  syms_low_q  <= cfg_wdata_i;
        CFG_SYMBOLS_HIGH: syms_high_q <= cfg_wdata_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_comb begin
    accept   = start_i && (state_q == S_IDLE);
    range_ok = (count_q >= MIN_RADIX) && (count_q <= 5'(MAX_SYMBOLS));
    // two's complement magnitude; the most negative value maps to 2^31
    mag_in   = value_i[31] ? 32'(~$unsigned(value_i) + 32'd1) : $unsigned(value_i);
    // first division on accept, then divide the quotient again until it is zero
    div_start = (accept && range_ok) ||
                ((state_q == S_CONV) && div_res.done && (div_res.quot != 32'd0));
    div_dividend = (state_q == S_IDLE) ? mag_in : div_res.quot;
  end

  rdf_divstep u_divstep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .radix_i    (count_q),
    .recip_i    (recip_of(count_q)),
    .result_o   (div_res)
  );

  rdf_symcheck #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_symcheck (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && range_ok),
    .count_i   (count_q),
    .symbols_i (syms),
    .status_o  (chk_res)
  );

  // digit store, least significant digit at index 0
  always_ff @(posedge clk_i) begin
    if ((state_q == S_CONV) && div_res.done) begin
      digits_q[wr_idx_q] <= div_res.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      symbol_q    <= '0;
      is_last_q   <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          // an accepted value with an out-of-range count yields nothing
          if (accept && range_ok) begin
            neg_q    <= value_i[31];
            wr_idx_q <= '0;
            state_q  <= S_CONV;
          end
        end
        S_CONV: begin
          if (div_res.done) begin
            wr_idx_q <= wr_idx_q + 5'd1;
            rd_idx_q <= wr_idx_q;
            if (div_res.quot == 32'd0) begin
              state_q <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (chk_res.done) begin
            if (!chk_res.ok) begin
              state_q <= S_IDLE;
            end else begin
              if (neg_q) begin
                out_valid_q <= 1'b1;
                symbol_q    <= CHAR_MINUS;
                is_last_q   <= 1'b0;
              end
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          // walk the digit store from the most significant digit down
          out_valid_q <= 1'b1;
          symbol_q    <= sym_at(syms, digits_q[rd_idx_q]);
          is_last_q   <= rd_idx_q == 5'd0;
          if (rd_idx_q == 5'd0) begin
            state_q <= S_IDLE;
          end else begin
            rd_idx_q <= rd_idx_q - 5'd1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o         = state_q != S_IDLE;
  assign symbol_valid_o = out_valid_q;
  assign symbol_o       = symbol_q;
  assign is_last_o      = is_last_q;

`ifndef ASSERT_OFF
  // the divider is only restarted once it has finished the previous digit
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_res.busy)
    else $error("divider started while busy");

  // the final character closes the transaction: no strobe follows directly
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (symbol_valid_o && is_last_o) |=> !symbol_valid_o)
    else $error("character issued after the last one");

  // characters only follow a transaction in progress
  a_valid_in_txn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    symbol_valid_o |-> $past(busy_o))
    else $error("character issued outside a transaction");

  // in the emit state, the symbol check has always finished its sweep and passed
  a_chk_before_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> chk_res.done && chk_res.ok)
    else $error("characters issued without a passed symbol check");
`endif

endmodule

@@ rtl/core/rdf_divstep.sv @@
// Shared divide-by-radix unit: reciprocal multiply, back-multiply, correct.
module rdf_divstep import rdf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [4:0]  radix_i,
  input  logic [31:0] recip_i,
  output div_result_t result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_BACK,
    S_FIX
  } div_state_e;

  div_state_e  state_q;
  logic [31:0] dividend_q;
  logic [31:0] est_q;
  logic [31:0] back_q;
  logic [31:0] quot_q;
  logic [3:0]  rem_q;
  logic        done_q;

  logic [63:0] prod;
  logic [36:0] back_full;
  logic [31:0] rem_full;
  logic        fix;

  always_comb begin
    prod      = 64'(dividend_q) * 64'(recip_i);
    back_full = 37'(est_q) * 37'(radix_i);
    rem_full  = dividend_q - back_q;
    fix       = rem_full >= 32'(radix_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            dividend_q <= dividend_i;
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          // estimate is exact or one low
          est_q   <= prod[63:32];
          state_q <= S_BACK;
        end
        S_BACK: begin
          back_q  <= back_full[31:0];
          state_q <= S_FIX;
        end
        S_FIX: begin
          quot_q  <= est_q + 32'(fix);
          rem_q   <= fix ? 4'(rem_full - 32'(radix_i)) : rem_full[3:0];
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.busy = state_q != S_IDLE;
  assign result_o.done = done_q;
  assign result_o.quot = quot_q;
  assign result_o.rem  = rem_q;

endmodule

@@ rtl/core/rdf_symcheck.sv @@
// Symbol set checker: sweeps the symbols one per cycle for range, sign characters and duplicates.
module rdf_symcheck import rdf_pkg::*; #(
  parameter int MAX_SYMBOLS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [4:0]   count_i,
  input  logic [127:0] symbols_i,
  output chk_status_t  status_o
);

  typedef enum logic {
    C_IDLE,
    C_RUN
  } chk_state_e;

  chk_state_e state_q;
  logic [3:0] idx_q;
  logic       done_q;
  logic       ok_q;

  logic [7:0] sym;
  logic       bad_char;
  logic       dup;
  logic       count_ok;
  logic       at_end;

  always_comb begin
    sym      = sym_at(symbols_i, idx_q);
    bad_char = (sym < CHAR_LOW) || (sym > CHAR_HIGH) || (sym == CHAR_PLUS) ||
               (sym == CHAR_MINUS);
    dup      = 1'b0;
    for (int j = 0; j < 16; j++) begin
      if ((4'(j) > idx_q) && (5'(j) < count_i) && (symbols_i[j*8 +: 8] == sym)) begin
        dup = 1'b1;
      end
    end
    count_ok = (count_i >= MIN_RADIX) && (count_i <= 5'(MAX_SYMBOLS));
    at_end   = {1'b0, idx_q} == (count_i - 5'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
      ok_q    <= 1'b0;
    end else begin
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            idx_q <= '0;
            ok_q  <= 1'b0;
            if (count_ok) begin
              done_q  <= 1'b0;
              state_q <= C_RUN;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        C_RUN: begin
          if (bad_char || dup) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else if (at_end) begin
            done_q  <= 1'b1;
            ok_q    <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  assign status_o.done = done_q;
  assign status_o.ok   = ok_q;

endmodule
